// File: design/gnfm_pkg.sv
// Shared types, sizes and codes for the gated nearest feature match unit.
package gnfm_pkg;

    localparam int MAX_STORED = 64;
    localparam int ADDR_W     = $clog2(MAX_STORED);
    localparam int CNT_W      = $clog2(MAX_STORED + 1);

    localparam logic [1:0]  MODE_LOAD  = 2'd0;
    localparam logic [1:0]  MODE_QUERY = 2'd1;
    localparam logic [1:0]  MODE_CLEAR = 2'd2;

    localparam logic [23:0] GATE_RESET = 24'd4096;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic [15:0]        feature_id;
    } item_t;

    typedef struct packed {
        logic [15:0] query_id;
        logic [15:0] match_id;
        logic        matched;
    } result_t;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic              q_start;
        logic [ADDR_W-1:0] addr;
    } ctl_t;

    typedef struct packed {
        logic pipe_busy;
    } sts_t;

endpackage

// File: design/gnfm_ctrl.sv
// Controller: table fill count, scan sequencing and result strobe.
module gnfm_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [1:0]    mode,
    output logic          busy,
    output logic          done,
    output gnfm_pkg::ctl_t ctl,
    input  gnfm_pkg::sts_t sts
);
    import gnfm_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            addr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            addr_reg  <= addr_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        addr_next   = addr_reg;
        ctl.wr_en   = 1'b0;
        ctl.rd_en   = 1'b0;
        ctl.q_start = 1'b0;
        ctl.addr    = count_reg[ADDR_W-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (mode)
                        MODE_LOAD:
                        begin
                            // drop loads into a full table
                            if (count_reg < CNT_W'(MAX_STORED))
                            begin
                                ctl.wr_en  = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            count_next = '0;
                        end
                        MODE_QUERY:
                        begin
                            ctl.q_start = 1'b1;
                            addr_next   = '0;
                            state_next  = (count_reg == '0) ? ST_DRAIN : ST_SCAN;
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                ctl.rd_en = 1'b1;
                ctl.addr  = addr_reg;
                if (CNT_W'(addr_reg) + 1'b1 == count_reg)
                    state_next = ST_DRAIN;
                else
                    addr_next = addr_reg + 1'b1;
            end
            ST_DRAIN:
            begin
                // wait until the last entry has passed the compare stage
                if (!sts.pipe_busy)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

endmodule

// File: design/gnfm_dp.sv
// Datapath: feature table, distance pipeline and best-match tracking.
module gnfm_dp (
    input  logic             clk,
    input  logic             rst_n,
    input  gnfm_pkg::item_t  item,
    input  logic             cfg_wr_en,
    input  logic [23:0]      cfg_wr_data,
    input  gnfm_pkg::ctl_t   ctl,
    output gnfm_pkg::sts_t   sts,
    output gnfm_pkg::result_t result
);
    import gnfm_pkg::*;

    typedef struct packed {
        logic [23:0] x;
        logic [23:0] y;
        logic [15:0] id;
    } entry_t;

    entry_t mem [MAX_STORED];

    logic [23:0] gate_reg;
    logic [23:0] qx_reg, qy_reg;
    logic [15:0] qid_reg;
    logic [47:0] best_reg;
    logic [15:0] best_id_reg;
    logic        found_reg;

    logic        vld1_reg, vld2_reg, vld3_reg, vld4_reg;
    entry_t      rdata_reg;
    logic [24:0] ax_reg, ay_reg;
    logic [15:0] id2_reg, id3_reg, id4_reg;
    logic [49:0] sqx_reg, sqy_reg;
    logic [49:0] sum_reg;

    logic signed [24:0] dx, dy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_reg <= GATE_RESET;
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                gate_reg <= cfg_wr_data;
            vld1_reg <= ctl.rd_en;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
            mem[ctl.addr] <= '{x: item.pos_x, y: item.pos_y, id: item.feature_id};
        if (ctl.rd_en)
            rdata_reg <= mem[ctl.addr];
    end

    assign dx = $signed({rdata_reg.x[23], rdata_reg.x}) - $signed({qx_reg[23], qx_reg});
    assign dy = $signed({rdata_reg.y[23], rdata_reg.y}) - $signed({qy_reg[23], qy_reg});

    always_ff @(posedge clk)
    begin
        ax_reg  <= dx[24] ? 25'(-dx) : 25'(dx);
        ay_reg  <= dy[24] ? 25'(-dy) : 25'(dy);
        id2_reg <= rdata_reg.id;

        sqx_reg <= ax_reg * ax_reg;
        sqy_reg <= ay_reg * ay_reg;
        id3_reg <= id2_reg;

        sum_reg <= sqx_reg + sqy_reg;
        id4_reg <= id3_reg;

        if (ctl.q_start)
        begin
            qx_reg      <= item.pos_x;
            qy_reg      <= item.pos_y;
            qid_reg     <= item.feature_id;
            best_reg    <= gate_reg * gate_reg;
            best_id_reg <= '0;
            found_reg   <= 1'b0;
        end
        else if (vld4_reg && (sum_reg < {2'b00, best_reg}))
        begin
            // strict compare keeps the earliest entry on ties
            best_reg    <= sum_reg[47:0];
            best_id_reg <= id4_reg;
            found_reg   <= 1'b1;
        end
    end

    assign sts.pipe_busy   = vld1_reg | vld2_reg | vld3_reg | vld4_reg;
    assign result.query_id = qid_reg;
    assign result.match_id = best_id_reg;
    assign result.matched  = found_reg;

endmodule

// File: design/gated_nearest_feature_match_unit.sv
// Top level of the gated nearest feature match unit.
//
//  Channel   Handshake            Payload          Notes
//  item      start / busy         cmd (item_t)     taken when start && !busy
//  result    done (strobe)        result           valid for one cycle only
//  config    cfg_wr_en            cfg_wr_data      gate distance, Q12.12
//
// Load, clear and ignored mode-3 beats are taken while idle and leave busy low.
// A query holds busy while it reads the N stored entries (N up to 64), one
// table read per cycle through a single-port memory, or goes straight to the
// drain on an empty table; a four-stage distance pipeline then drains before
// the result strobe.
// Reset empties the table and sets the gate to 1.0; the result side cannot stall.
module gated_nearest_feature_match_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  gnfm_pkg::item_t    cmd,
    output logic               done,
    output gnfm_pkg::result_t  result,
    input  logic               cfg_wr_en,
    input  logic [23:0]        cfg_wr_data
);
    import gnfm_pkg::*;

    ctl_t ctl;
    sts_t sts;

    gnfm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (cmd.mode),
        .busy  (busy),
        .done  (done),
        .ctl   (ctl),
        .sts   (sts)
    );

    gnfm_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (cmd),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .ctl         (ctl),
        .sts         (sts),
        .result      (result)
    );

`ifndef SYNTHESIS
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe while idle");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.mode == MODE_QUERY) |=> busy)
        else $error("query beat did not start a scan");

    a_unmatched_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.matched) |-> (result.match_id == '0))
        else $error("unmatched result carries a nonzero id");
`endif

endmodule

// File: tb/gnfm_match_checker.sv
// Checker for the match unit: mirrors the feature table and scores every result beat.
module gnfm_match_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  gnfm_pkg::item_t     cmd,
    input  logic                done,
    input  gnfm_pkg::result_t   result,
    input  logic                cfg_wr_en,
    input  logic [23:0]         cfg_wr_data,
    output int                  fail_count,
    output int                  outstanding
);
    import gnfm_pkg::*;

    localparam int EXP_DEPTH = 16;

    logic [23:0]        gate_q;
    logic signed [23:0] map_x [MAX_STORED];
    logic signed [23:0] map_y [MAX_STORED];
    logic [15:0]        map_id [MAX_STORED];
    int                 map_count;
    result_t            exp_fifo [EXP_DEPTH];
    int                 exp_wr;
    int                 exp_rd;
    result_t            want;

    // Nearest stored entry strictly inside the squared gate; first one wins on ties.
    function automatic result_t nearest_in_gate(input item_t q);
        result_t r;
        longint  best;
        longint  dx;
        longint  dy;
        longint  d2;
        int      i;
        r.query_id = q.feature_id;
        r.match_id = '0;
        r.matched  = 1'b0;
        best = longint'(gate_q) * longint'(gate_q);
        for (i = 0; i < map_count; i++) begin
            dx = longint'(q.pos_x) - longint'(map_x[i]);
            dy = longint'(q.pos_y) - longint'(map_y[i]);
            d2 = dx * dx + dy * dy;
            if (d2 < best) begin
                best       = d2;
                r.match_id = map_id[i];
                r.matched  = 1'b1;
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            gate_q      = GATE_RESET;
            map_count   = 0;
            exp_wr      = 0;
            exp_rd      = 0;
            fail_count  = 0;
            outstanding = 0;
        end else begin
            if (done) begin
                if (exp_wr == exp_rd) begin
                    $error("unexpected result beat: query_id %0d match_id %0d matched %0b",
                           result.query_id, result.match_id, result.matched);
                    fail_count++;
                end else begin
                    want = exp_fifo[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    if (result.query_id !== want.query_id) begin
                        $error("query_id: expected %0d, actual %0d",
                               want.query_id, result.query_id);
                        fail_count++;
                    end
                    if (result.match_id !== want.match_id) begin
                        $error("match_id: expected %0d, actual %0d",
                               want.match_id, result.match_id);
                        fail_count++;
                    end
                    if (result.matched !== want.matched) begin
                        $error("matched: expected %0b, actual %0b",
                               want.matched, result.matched);
                        fail_count++;
                    end
                end
            end
            if (cfg_wr_en)
                gate_q = cfg_wr_data;
            if (start && !busy) begin
                case (cmd.mode)
                    MODE_LOAD:
                        // drop loads into a full table
                        if (map_count < MAX_STORED) begin
                            map_x[map_count]  = cmd.pos_x;
                            map_y[map_count]  = cmd.pos_y;
                            map_id[map_count] = cmd.feature_id;
                            map_count++;
                        end
                    MODE_QUERY:
                    begin
                        exp_fifo[exp_wr % EXP_DEPTH] = nearest_in_gate(cmd);
                        exp_wr++;
                    end
                    MODE_CLEAR:
                        map_count = 0;
                    default:
                        ;
                endcase
            end
            outstanding = exp_wr - exp_rd;
        end
    end

endmodule

// File: tb/tb_gated_nearest_feature_match_unit.sv
// Top of the match unit testbench: clock, reset, stimulus and verdict.
module tb_gated_nearest_feature_match_unit;
    import gnfm_pkg::*;

    localparam logic [1:0] MODE_NOP     = 2'd3;
    localparam int         CYCLE_LIMIT  = 800000;
    localparam int         DRAIN_CYCLES = MAX_STORED + 16;
    localparam int         PHASE_ITEMS  = 200;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    item_t       cmd;
    logic        done;
    result_t     result;
    logic        cfg_wr_en;
    logic [23:0] cfg_wr_data;

    int          fail_count;
    int          outstanding;
    int          cycle_count = 0;
    int          items_sent = 0;
    bit          no_gaps = 1'b0;
    logic [23:0] gate_now = GATE_RESET;

    // stimulus-side copy of loaded positions, used only to aim queries
    logic signed [23:0] loaded_x [MAX_STORED];
    logic signed [23:0] loaded_y [MAX_STORED];
    int                 loaded_count = 0;

    gated_nearest_feature_match_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .done        (done),
        .result      (result),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    gnfm_match_checker match_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .done        (done),
        .result      (result),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_gated_nearest_feature_match_unit: FAIL");
            $finish;
        end
    end

    // Present one beat after a random gap and hold it until the block takes it.
    task automatic send_beat(input logic [1:0] mode, input logic signed [23:0] x,
                             input logic signed [23:0] y, input logic [15:0] id);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 12);
        @(negedge clk);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start           = 1'b1;
        cmd.mode        = mode;
        cmd.pos_x       = x;
        cmd.pos_y       = y;
        cmd.feature_id  = id;
        do
            @(posedge clk);
        while (busy);
        if (mode != MODE_NOP)
            items_sent++;
    endtask

    task automatic load_feature(input logic signed [23:0] x, input logic signed [23:0] y,
                                input logic [15:0] id);
        send_beat(MODE_LOAD, x, y, id);
        if (loaded_count < MAX_STORED)
        begin
            loaded_x[loaded_count] = x;
            loaded_y[loaded_count] = y;
            loaded_count++;
        end
    endtask

    task automatic clear_table();
        send_beat(MODE_CLEAR, 24'($urandom), 24'($urandom), 16'($urandom));
        loaded_count = 0;
    endtask

    // Hold off until every result is back, then let the pipeline drain.
    task automatic wait_idle();
        @(negedge clk);
        start = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_gate(input logic [23:0] value);
        wait_idle();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        gate_now    = value;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
    endtask

    // Query close to a stored entry, or anywhere when the table is empty or at random.
    task automatic query_near();
        int                 idx;
        int                 r;
        int                 ox;
        int                 oy;
        logic signed [23:0] qx;
        logic signed [23:0] qy;
        if (loaded_count == 0 || $urandom_range(0, 3) == 0)
        begin
            qx = 24'($urandom);
            qy = 24'($urandom);
        end
        else
        begin
            idx = $urandom_range(0, loaded_count - 1);
            r   = (gate_now == 0) ? 2 : ((gate_now > 24'h200000) ? 24'h200000 : gate_now);
            ox  = int'($urandom_range(0, 2 * r)) - r;
            oy  = int'($urandom_range(0, 2 * r)) - r;
            if ($urandom_range(0, 7) == 0)
            begin
                ox = 0;
                oy = 0;
            end
            qx  = 24'(loaded_x[idx] + ox);
            qy  = 24'(loaded_y[idx] + oy);
        end
        send_beat(MODE_QUERY, qx, qy, 16'($urandom));
    endtask

    // Random work: clears, clustered loads, then queries aimed at them and ignored beats.
    task automatic run_phase(input int n_items);
        int                 target;
        int                 n_loads;
        int                 n_queries;
        int                 spread;
        int                 k;
        int                 idx;
        logic signed [23:0] cx;
        logic signed [23:0] cy;
        logic signed [23:0] lx;
        logic signed [23:0] ly;
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 5) == 0)
                no_gaps = !no_gaps;
            if ($urandom_range(0, 3) == 0)
                clear_table();
            n_loads   = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 72)
                                                    : $urandom_range(0, 10);
            cx        = 24'($urandom);
            cy        = 24'($urandom);
            spread    = 1 << (8 + 4 * $urandom_range(0, 3));
            for (k = 0; k < n_loads; k++)
            begin
                if (loaded_count > 0 && $urandom_range(0, 7) == 0)
                begin
                    // same position as an earlier entry: earliest must win
                    idx = $urandom_range(0, loaded_count - 1);
                    lx  = loaded_x[idx];
                    ly  = loaded_y[idx];
                end
                else if (spread >= (1 << 20) && $urandom_range(0, 1) == 0)
                begin
                    lx = 24'($urandom);
                    ly = 24'($urandom);
                end
                else
                begin
                    lx = 24'(cx + int'($urandom_range(0, 2 * spread)) - spread);
                    ly = 24'(cy + int'($urandom_range(0, 2 * spread)) - spread);
                end
                load_feature(lx, ly, 16'($urandom));
            end
            n_queries = $urandom_range(1, 8);
            for (k = 0; k < n_queries; k++)
                query_near();
            if ($urandom_range(0, 9) == 0)
                send_beat(MODE_NOP, 24'($urandom), 24'($urandom), 16'($urandom));
            if ($urandom_range(0, 15) == 0)
                wait_idle();
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // directed: empty table, ignored mode, extremes, ties, gate boundary
        send_beat(MODE_QUERY, 24'sd0, 24'sd0, 16'h1234);
        send_beat(MODE_NOP, -24'sd1, -24'sd1, 16'hFFFF);
        load_feature(24'sd8388607, 24'sd8388607, 16'hFFFF);
        load_feature(-24'sd8388608, -24'sd8388608, 16'h0000);
        load_feature(24'sd0, 24'sd0, 16'h0001);
        load_feature(24'sd0, 24'sd0, 16'h0002);
        send_beat(MODE_QUERY, 24'sd0, 24'sd0, 16'hFFFF);
        send_beat(MODE_QUERY, 24'sd4096, 24'sd0, 16'h0003);
        send_beat(MODE_QUERY, 24'sd4095, 24'sd0, 16'h0004);
        send_beat(MODE_QUERY, 24'sd8388607, 24'sd8388607, 16'h0005);
        send_beat(MODE_QUERY, -24'sd8388608, -24'sd8388608, 16'h0006);
        send_beat(MODE_QUERY, 24'sd2896, 24'sd2896, 16'h0007);
        write_gate(24'd0);
        send_beat(MODE_QUERY, 24'sd0, 24'sd0, 16'h0008);
        write_gate(24'hFFFFFF);
        send_beat(MODE_QUERY, -24'sd8388608, 24'sd8388607, 16'h0009);
        send_beat(MODE_QUERY, 24'sd8388607, -24'sd8388608, 16'h000A);
        clear_table();
        send_beat(MODE_QUERY, 24'sd0, 24'sd0, 16'h000B);

        write_gate(GATE_RESET);
        run_phase(PHASE_ITEMS);
        write_gate(24'($urandom_range(1, 255)));
        run_phase(PHASE_ITEMS);
        write_gate(24'($urandom_range(4096, 1 << 18)));
        run_phase(PHASE_ITEMS);
        write_gate(24'hFFFFFF);
        run_phase(PHASE_ITEMS);
        write_gate(24'd0);
        run_phase(PHASE_ITEMS / 2);
        write_gate(24'($urandom_range(0, 24'hFFFFFF)));
        run_phase(PHASE_ITEMS);

        wait_idle();
        if (fail_count == 0)
            $display("tb_gated_nearest_feature_match_unit: PASS");
        else
            $display("tb_gated_nearest_feature_match_unit: FAIL");
        $finish;
    end

endmodule

// File: files.f
design/gnfm_pkg.sv
design/gnfm_ctrl.sv
design/gnfm_dp.sv
design/gated_nearest_feature_match_unit.sv
tb/gnfm_match_checker.sv
tb/tb_gated_nearest_feature_match_unit.sv
